### src/lbt_pkg.sv
// Shared types, constants and a helper function for the LED, beeper and tick controller.
// Depends on nothing; every other source file imports it.
package lbt_pkg;

    // Length of one timer tick in milliseconds.
    localparam logic [4:0] TICK_MS = 5'd2;

    localparam int unsigned MS_W    = 16;
    localparam int unsigned LEVEL_W = 10;
    localparam int unsigned CFG_A_W = 2;

    localparam logic [MS_W-1:0]    MS_MAX    = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    localparam logic [MS_W-1:0]    BEEP_PERIOD_RST  = 16'd50;
    localparam logic [MS_W-1:0]    BLINK_PERIOD_RST = 16'd100;
    localparam logic [LEVEL_W-1:0] BREATH_TOP_RST   = 10'd1000;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_BEEP_PERIOD  = 2'd0,
        CFG_BLINK_PERIOD = 2'd1,
        CFG_BREATH_TOP   = 2'd2
    } t_cfg_addr;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_BLINK  = 2'd1,
        MODE_BREATH = 2'd2
    } t_led_mode;

    typedef struct packed {
        logic [MS_W-1:0]    beep_period_ms;
        logic [MS_W-1:0]    blink_period_ms;
        logic [LEVEL_W-1:0] breath_top;
    } t_cfg;

    typedef struct packed {
        logic [1:0] led_mode;
        logic       beep_start;
        logic       button_held;
        logic       button_clear;
    } t_tick;

    typedef struct packed {
        logic               beep_active;
        logic               beep_sounding;
        logic [MS_W-1:0]    beep_elapsed;
        logic [MS_W-1:0]    button_elapsed;
        logic [MS_W-1:0]    blink_elapsed;
        logic               blink_which;
        logic               blink_lit;
        logic [LEVEL_W-1:0] breath_level;
        logic               breath_rising;
    } t_state;

    typedef struct packed {
        logic               beeper_drive;
        logic               beeper_busy;
        logic               led_one_on;
        logic               led_two_on;
        logic [LEVEL_W-1:0] pwm_compare;
        logic [MS_W-1:0]    button_elapsed_ms;
    } t_result;

    // Adds one tick to a millisecond counter, holding at full scale.
    function automatic logic [MS_W-1:0] add_tick_sat(input logic [MS_W-1:0] a);
        logic [MS_W:0] sum;
        sum = {1'b0, a} + (MS_W + 1)'(TICK_MS);
        return sum[MS_W] ? MS_MAX : sum[MS_W-1:0];
    endfunction

endpackage

### src/led_beeper_tick_controller_core.sv
// A tick's result is registered in the output register, or in the skid entry if stalled.
// Throughput: one tick per cycle while the two-entry output buffer has room; the state
// update is a single pass of compares and increments on the state registers.
// Reset (i_rst_n low, synchronous) clears all timers and phases, sets breathing to rising,
// loads the default periods (50 ms beep, 100 ms blink, top 1000) and empties the buffer.
// Depends on lbt_pkg and lbt_step.
module led_beeper_tick_controller_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_we,
    input  logic [lbt_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [lbt_pkg::MS_W-1:0]     i_cfg_data,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_led_mode,
    input  logic                         i_beep_start,
    input  logic                         i_button_held,
    input  logic                         i_button_clear,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_beeper_drive,
    output logic                         o_beeper_busy,
    output logic                         o_led_one_on,
    output logic                         o_led_two_on,
    output logic [lbt_pkg::LEVEL_W-1:0]  o_pwm_compare,
    output logic [lbt_pkg::MS_W-1:0]     o_button_elapsed_ms
);
    import lbt_pkg::*;

    // Configuration registers, to be written only while the block is idle; the block does not enforce this.
    t_cfg    r_cfg;

    // Controller state, updated at every tick transfer.
    t_state  r_state;
    t_state  n_state;

    // Output register plus a skid entry. The skid entry catches a tick that arrives
    // while the output register is held by the downstream stall.
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_skid;
    t_result n_skid;
    logic    r_skid_valid;
    logic    n_skid_valid;

    t_tick   w_tick;
    t_result w_result;
    logic    w_in_xfer;
    logic    w_out_free;

    assign w_tick = '{
        led_mode:     i_led_mode,
        beep_start:   i_beep_start,
        button_held:  i_button_held,
        button_clear: i_button_clear
    };

    lbt_step u_step (
        .i_cfg    (r_cfg),
        .i_tick   (w_tick),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // Input is stalled only when the skid entry is occupied, which is a register.
    assign o_in_stall = r_skid_valid;
    assign w_in_xfer  = i_in_valid & ~r_skid_valid;
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (w_out_free) begin
            // The output register moves on: refill from the skid entry first, since
            // it is older; no new tick can be transferred while it is occupied.
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (w_in_xfer) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_in_xfer) begin
            n_skid       = w_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beep_period_ms  <= BEEP_PERIOD_RST;
            r_cfg.blink_period_ms <= BLINK_PERIOD_RST;
            r_cfg.breath_top      <= BREATH_TOP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BEEP_PERIOD:  r_cfg.beep_period_ms  <= i_cfg_data;
                CFG_BLINK_PERIOD: r_cfg.blink_period_ms <= i_cfg_data;
                CFG_BREATH_TOP:   r_cfg.breath_top      <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                    // Writes to an unused index are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{
                beep_active:    1'b0,
                beep_sounding:  1'b0,
                beep_elapsed:   '0,
                button_elapsed: '0,
                blink_elapsed:  '0,
                blink_which:    1'b0,
                blink_lit:      1'b0,
                breath_level:   '0,
                breath_rising:  1'b1
            };
        end else if (w_in_xfer) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid         = r_out_valid;
    assign o_beeper_drive      = r_out.beeper_drive;
    assign o_beeper_busy       = r_out.beeper_busy;
    assign o_led_one_on        = r_out.led_one_on;
    assign o_led_two_on        = r_out.led_two_on;
    assign o_pwm_compare       = r_out.pwm_compare;
    assign o_button_elapsed_ms = r_out.button_elapsed_ms;

endmodule

### src/lbt_step.sv
// Next-state and result logic for one timer tick of the controller.
// Purely combinational; depends on lbt_pkg.
module lbt_step (
    input  lbt_pkg::t_cfg    i_cfg,
    input  lbt_pkg::t_tick   i_tick,
    input  lbt_pkg::t_state  i_state,
    output lbt_pkg::t_state  o_state,
    output lbt_pkg::t_result o_result
);
    import lbt_pkg::*;

    always_comb begin
        t_state s;
        logic   one;
        logic   two;
        logic [LEVEL_W-1:0] pwm;

        s   = i_state;
        one = 1'b0;
        two = 1'b0;
        pwm = '0;

        // The one-shot beeper arms only from idle, then runs in the same tick.
        if (i_tick.beep_start) begin
            s.beep_active = 1'b1;
        end
        if (s.beep_active) begin
            if (s.beep_elapsed >= i_cfg.beep_period_ms) begin
                if (s.beep_sounding) begin
                    s.beep_sounding = 1'b0;
                    s.beep_active   = 1'b0;
                end else begin
                    s.beep_sounding = 1'b1;
                end
                s.beep_elapsed = '0;
            end
            s.beep_elapsed = add_tick_sat(s.beep_elapsed);
        end else begin
            s.beep_elapsed = '0;
        end

        // Clear takes priority over counting.
        priority if (i_tick.button_clear) begin
            s.button_elapsed = '0;
        end else if (i_tick.button_held) begin
            s.button_elapsed = add_tick_sat(s.button_elapsed);
        end else begin
            // Released button: the timer keeps its value.
        end

        unique case (i_tick.led_mode)
            MODE_BLINK: begin
                if (s.blink_elapsed >= i_cfg.blink_period_ms) begin
                    if (s.blink_lit) begin
                        s.blink_lit   = 1'b0;
                        s.blink_which = ~s.blink_which;
                    end else begin
                        s.blink_lit = 1'b1;
                    end
                    s.blink_elapsed = '0;
                end
                one = s.blink_lit & ~s.blink_which;
                two = s.blink_lit & s.blink_which;
                s.blink_elapsed = add_tick_sat(s.blink_elapsed);
            end
            MODE_BREATH: begin
                if (s.breath_rising) begin
                    if (s.breath_level != LEVEL_MAX) begin
                        s.breath_level = s.breath_level + LEVEL_W'(1);
                    end
                end else if (s.breath_level != '0) begin
                    s.breath_level = s.breath_level - LEVEL_W'(1);
                end
                priority if (s.breath_level >= i_cfg.breath_top) begin
                    s.breath_rising = 1'b0;
                end else if (s.breath_level == '0) begin
                    s.breath_rising = 1'b1;
                end else begin
                    // Between the limits the direction is kept.
                end
                pwm = s.breath_level;
                s.blink_elapsed = add_tick_sat(s.blink_elapsed);
            end
            default: begin
                // Idle and the unused code leave all LED state alone.
            end
        endcase

        o_state                    = s;
        o_result.beeper_drive      = s.beep_sounding;
        o_result.beeper_busy       = s.beep_active;
        o_result.led_one_on        = one;
        o_result.led_two_on        = two;
        o_result.pwm_compare       = pwm;
        o_result.button_elapsed_ms = s.button_elapsed;
    end

endmodule

### src/lbt_checker.sv
// Port-level checks for the controller core, attached by the bind at the end of the file.
// Depends on lbt_pkg and led_beeper_tick_controller_core.
module lbt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_beeper_drive,
    input logic                         o_beeper_busy,
    input logic                         o_led_one_on,
    input logic                         o_led_two_on,
    input logic [lbt_pkg::LEVEL_W-1:0]  o_pwm_compare,
    input logic [lbt_pkg::MS_W-1:0]     o_button_elapsed_ms
);
    import lbt_pkg::*;

    // A result held by a stall stays offered, with its beeper drive, PWM compare and button time unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_beeper_drive)
            && $stable(o_pwm_compare) && $stable(o_button_elapsed_ms))
        else $error("stalled result changed");

    // The beeper can only sound inside an active beep sequence.
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_beeper_drive |-> o_beeper_busy)
        else $error("beeper sounding while sequence inactive");

    // Blink mode lights at most one LED, and breathing leaves the blink outputs dark.
    a_led_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_led_one_on && o_led_two_on)
            && ((o_pwm_compare == '0) || !(o_led_one_on || o_led_two_on)))
        else $error("LED outputs conflict");

    // No result may appear, and input may not stall, in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("buffer not empty after reset");

    // Input stalls only when a result is already waiting behind a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && $past(i_out_stall))
        else $error("input stalled without downstream backpressure");

endmodule

bind led_beeper_tick_controller_core lbt_checker u_lbt_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_beeper_drive      (o_beeper_drive),
    .o_beeper_busy       (o_beeper_busy),
    .o_led_one_on        (o_led_one_on),
    .o_led_two_on        (o_led_two_on),
    .o_pwm_compare       (o_pwm_compare),
    .o_button_elapsed_ms (o_button_elapsed_ms)
);

### sim/lbt_tick_checker.sv
`timescale 1ns / 100ps
// Result checker for led_beeper_tick_controller_core: it mirrors the registers and the tick state,
// predicts one result per tick transfer and compares every result transfer against it.
// Depends on lbt_pkg for the register, tick, state and result types.
module lbt_tick_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_we,
    input  logic [lbt_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [lbt_pkg::MS_W-1:0]     i_cfg_data,

    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [1:0]                   i_led_mode,
    input  logic                         i_beep_start,
    input  logic                         i_button_held,
    input  logic                         i_button_clear,

    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_beeper_drive,
    input  logic                         i_beeper_busy,
    input  logic                         i_led_one_on,
    input  logic                         i_led_two_on,
    input  logic [lbt_pkg::LEVEL_W-1:0]  i_pwm_compare,
    input  logic [lbt_pkg::MS_W-1:0]     i_button_elapsed_ms,

    output int unsigned                  o_fail_count,
    output int unsigned                  o_results_due,
    output int unsigned                  o_results_checked
);
    import lbt_pkg::*;

    t_cfg        mirror_cfg;
    t_state      mirror;
    t_result     tick_results_due[$];
    int unsigned fail_total;
    int unsigned checked_total;

    function automatic logic [MS_W-1:0] ms_plus_tick(input logic [MS_W-1:0] ms);
        int unsigned sum;
        sum = 32'(ms) + 32'(TICK_MS);
        return (sum > 32'(MS_MAX)) ? MS_MAX : MS_W'(sum);
    endfunction

    // One tick: beeper arming, beeper phases, button timer, then the LED mode.
    task automatic advance_tick(input t_tick tk, output t_result res);
        res = '0;

        if (tk.beep_start && !mirror.beep_active) begin
            mirror.beep_active = 1'b1;
        end
        if (mirror.beep_active) begin
            if (mirror.beep_elapsed >= mirror_cfg.beep_period_ms) begin
                if (mirror.beep_sounding) begin
                    mirror.beep_sounding = 1'b0;
                    mirror.beep_active   = 1'b0;
                end else begin
                    mirror.beep_sounding = 1'b1;
                end
                mirror.beep_elapsed = '0;
            end
            mirror.beep_elapsed = ms_plus_tick(mirror.beep_elapsed);
        end else begin
            mirror.beep_elapsed = '0;
        end

        if (tk.button_clear) begin
            mirror.button_elapsed = '0;
        end else if (tk.button_held) begin
            mirror.button_elapsed = ms_plus_tick(mirror.button_elapsed);
        end

        case (tk.led_mode)
            MODE_BLINK: begin
                if (mirror.blink_elapsed >= mirror_cfg.blink_period_ms) begin
                    if (mirror.blink_lit) begin
                        mirror.blink_lit   = 1'b0;
                        mirror.blink_which = ~mirror.blink_which;
                    end else begin
                        mirror.blink_lit = 1'b1;
                    end
                    mirror.blink_elapsed = '0;
                end
                res.led_one_on = mirror.blink_lit && !mirror.blink_which;
                res.led_two_on = mirror.blink_lit && mirror.blink_which;
            end
            MODE_BREATH: begin
                if (mirror.breath_rising) begin
                    if (mirror.breath_level != LEVEL_MAX) begin
                        mirror.breath_level = mirror.breath_level + LEVEL_W'(1);
                    end
                end else if (mirror.breath_level != '0) begin
                    mirror.breath_level = mirror.breath_level - LEVEL_W'(1);
                end
                if (mirror.breath_level >= mirror_cfg.breath_top) begin
                    mirror.breath_rising = 1'b0;
                end else if (mirror.breath_level == '0) begin
                    mirror.breath_rising = 1'b1;
                end
                res.pwm_compare = mirror.breath_level;
            end
            default: begin
            end
        endcase
        if (tk.led_mode == MODE_BLINK || tk.led_mode == MODE_BREATH) begin
            mirror.blink_elapsed = ms_plus_tick(mirror.blink_elapsed);
        end

        res.beeper_drive      = mirror.beep_sounding;
        res.beeper_busy       = mirror.beep_active;
        res.button_elapsed_ms = mirror.button_elapsed;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_tick   tick;
        t_result want;
        if (!i_rst_n) begin
            mirror_cfg.beep_period_ms  = BEEP_PERIOD_RST;
            mirror_cfg.blink_period_ms = BLINK_PERIOD_RST;
            mirror_cfg.breath_top      = BREATH_TOP_RST;
            mirror                     = '0;
            mirror.breath_rising       = 1'b1;
            tick_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_BEEP_PERIOD:  mirror_cfg.beep_period_ms  = i_cfg_data;
                    CFG_BLINK_PERIOD: mirror_cfg.blink_period_ms = i_cfg_data;
                    CFG_BREATH_TOP:   mirror_cfg.breath_top      = i_cfg_data[LEVEL_W-1:0];
                    default: begin
                    end
                endcase
            end
            // A result leaving at this edge belongs to an earlier tick, so it is matched
            // before the tick entering at the same edge is queued.
            if (i_out_valid && !i_out_stall) begin
                if (tick_results_due.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    fail_total++;
                end else begin
                    want = tick_results_due.pop_front();
                    compare_field("beeper_drive", 32'(want.beeper_drive), 32'(i_beeper_drive));
                    compare_field("beeper_busy", 32'(want.beeper_busy), 32'(i_beeper_busy));
                    compare_field("led_one_on", 32'(want.led_one_on), 32'(i_led_one_on));
                    compare_field("led_two_on", 32'(want.led_two_on), 32'(i_led_two_on));
                    compare_field("pwm_compare", 32'(want.pwm_compare), 32'(i_pwm_compare));
                    compare_field("button_elapsed_ms", 32'(want.button_elapsed_ms),
                                  32'(i_button_elapsed_ms));
                    checked_total++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                tick.led_mode     = i_led_mode;
                tick.beep_start   = i_beep_start;
                tick.button_held  = i_button_held;
                tick.button_clear = i_button_clear;
                advance_tick(tick, want);
                tick_results_due.push_back(want);
            end
        end
        o_fail_count      <= fail_total;
        o_results_due     <= tick_results_due.size();
        o_results_checked <= checked_total;
    end

endmodule

### sim/tb_led_beeper_tick_controller_core.sv
`timescale 1ns / 100ps
// Testbench top for led_beeper_tick_controller_core: drives ticks, register writes and output
// stalls, and gives the verdict. Depends on lbt_pkg, lbt_tick_checker and the core itself.
module tb_led_beeper_tick_controller_core;
    import lbt_pkg::*;

    // The mode field is two bits wide; its fourth code has no name in the package and the
    // block must treat it like idle.
    localparam logic [1:0] MODE_RESERVED    = 2'd3;
    localparam int         LONG_HOLD_CYCLES = 300;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr     = '0;
    logic [MS_W-1:0]    cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic [1:0]         led_mode     = MODE_IDLE;
    logic               beep_start   = 1'b0;
    logic               button_held  = 1'b0;
    logic               button_clear = 1'b0;
    logic               out_stall    = 1'b0;

    logic               in_stall;
    logic               out_valid;
    logic               beeper_drive;
    logic               beeper_busy;
    logic               led_one_on;
    logic               led_two_on;
    logic [LEVEL_W-1:0] pwm_compare;
    logic [MS_W-1:0]    button_elapsed_ms;

    int unsigned fail_count;
    int unsigned results_due;
    int unsigned results_checked;

    // Pacing of the tick sender, and bookkeeping for the closing summary.
    int          burst_left       = 1;
    int unsigned ticks_sent       = 0;
    int unsigned settings_applied = 0;

    // The stimulus raises this once; the receiver process answers with one long hold-off.
    logic long_hold_go   = 1'b0;
    logic long_hold_done = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    led_beeper_tick_controller_core dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_addr          (cfg_addr),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_led_mode          (led_mode),
        .i_beep_start        (beep_start),
        .i_button_held       (button_held),
        .i_button_clear      (button_clear),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_beeper_drive      (beeper_drive),
        .o_beeper_busy       (beeper_busy),
        .o_led_one_on        (led_one_on),
        .o_led_two_on        (led_two_on),
        .o_pwm_compare       (pwm_compare),
        .o_button_elapsed_ms (button_elapsed_ms)
    );

    lbt_tick_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_addr          (cfg_addr),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_led_mode          (led_mode),
        .i_beep_start        (beep_start),
        .i_button_held       (button_held),
        .i_button_clear      (button_clear),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_beeper_drive      (beeper_drive),
        .i_beeper_busy       (beeper_busy),
        .i_led_one_on        (led_one_on),
        .i_led_two_on        (led_two_on),
        .i_pwm_compare       (pwm_compare),
        .i_button_elapsed_ms (button_elapsed_ms),
        .o_fail_count        (fail_count),
        .o_results_due       (results_due),
        .o_results_checked   (results_checked)
    );

    // Offers one tick and holds it until the block takes it. Afterwards the sender either
    // keeps valid high for the next tick of the burst or, at the end of a burst, usually
    // drops valid before the next burst. Valid is only ever driven once per clock edge.
    task automatic offer_tick(input logic [1:0] mode, input logic start, held, clear);
        in_valid     <= 1'b1;
        led_mode     <= mode;
        beep_start   <= start;
        button_held  <= held;
        button_clear <= clear;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        ticks_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Random ticks. Breathing gets its own weight since the PWM level only moves in that
    // mode; the rest is mostly blinking with some idle and some of the unnamed mode code.
    task automatic random_ticks(input int count, breath_pct, held_pct, clear_pct);
        logic [1:0] mode;
        int         pick;
        repeat (count) begin
            if ($urandom_range(99) < breath_pct) begin
                mode = MODE_BREATH;
            end else begin
                pick = $urandom_range(9);
                if (pick < 2) begin
                    mode = MODE_IDLE;
                end else if (pick < 3) begin
                    mode = MODE_RESERVED;
                end else begin
                    mode = MODE_BLINK;
                end
            end
            offer_tick(mode, $urandom_range(99) < 12, $urandom_range(99) < held_pct,
                       $urandom_range(99) < clear_pct);
        end
    endtask

    // Stops sending and waits until every predicted result has been transferred out.
    // The first edge lets the checker account for the last tick taken in.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_addr addr, input logic [MS_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Registers are only rewritten once the block has gone quiet.
    task automatic apply_settings(input logic [MS_W-1:0] beep, blink,
                                  input logic [LEVEL_W-1:0] top);
        drain_results();
        write_reg(CFG_BEEP_PERIOD, beep);
        write_reg(CFG_BLINK_PERIOD, blink);
        write_reg(CFG_BREATH_TOP, MS_W'(top));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // The receiver stalls in segments: free running, random stalls at a random rate, or a
    // fixed periodic pattern. When asked, it holds off once for a long stretch.
    initial begin : receiver
        int kind;
        int seg_len;
        int pct;
        int i;
        forever begin
            kind    = $urandom_range(2);
            seg_len = $urandom_range(10, 200);
            pct     = $urandom_range(10, 70);
            for (i = 0; i < seg_len; i++) begin
                @(posedge clk);
                if (long_hold_go && !long_hold_done) begin
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD_CYCLES) @(posedge clk);
                    long_hold_done = 1'b1;
                end
                case (kind)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(99) < pct);
                    default: out_stall <= (i % 4 == 3);
                endcase
            end
        end
    end

    initial begin : stimulus
        int k;
        burst_left = $urandom_range(1, 40);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks under the reset periods: arming the beeper, a start while the
        // beeper is already busy, clear winning over held, every mode including the
        // unnamed code, and all fields at their extremes.
        offer_tick(MODE_IDLE, 1'b0, 1'b0, 1'b0);
        offer_tick(MODE_IDLE, 1'b1, 1'b1, 1'b0);
        offer_tick(MODE_BLINK, 1'b1, 1'b1, 1'b0);
        offer_tick(MODE_BLINK, 1'b0, 1'b1, 1'b1);
        offer_tick(MODE_BLINK, 1'b0, 1'b0, 1'b1);
        repeat (4) offer_tick(MODE_BREATH, 1'b0, 1'b1, 1'b0);
        offer_tick(MODE_RESERVED, 1'b1, 1'b1, 1'b1);
        offer_tick(MODE_RESERVED, 1'b0, 1'b0, 1'b0);
        offer_tick(MODE_IDLE, 1'b0, 1'b1, 1'b0);
        repeat (3) offer_tick(MODE_BLINK, 1'b0, 1'b1, 1'b0);
        offer_tick(MODE_BREATH, 1'b1, 1'b0, 1'b1);
        offer_tick(MODE_IDLE, 1'b0, 1'b0, 1'b0);

        // Zero periods: the beeper runs a two-tick sequence and the LEDs toggle every tick.
        // A top of one makes the breathing level bounce between zero and one.
        apply_settings('0, '0, 10'd1);
        random_ticks(150, 30, 50, 10);

        // Periods one below full scale, and a breathing top of zero, which pins the level near zero.
        apply_settings(16'd65534, 16'd65534, '0);
        random_ticks(60, 60, 50, 5);

        // Highest top: enough breathing ticks to climb all the way and turn back down.
        // The long output hold-off is requested here so the block backs up and stalls input.
        apply_settings(16'd6, 16'd4, LEVEL_MAX);
        long_hold_go <= 1'b1;
        random_ticks(1150, 95, 50, 5);

        // Random short periods. The first of these drops the top well below the level left
        // from the climb, so breathing must turn down at once. The middle one pauses the
        // sender until every result is out.
        for (k = 0; k < 3; k++) begin
            apply_settings(MS_W'($urandom_range(0, 40)), MS_W'($urandom_range(0, 60)),
                           LEVEL_W'($urandom_range(2, 40)));
            random_ticks(60, 35, 50, 8);
            if (k == 1) begin
                drain_results();
            end
            random_ticks(60, 35, 50, 8);
        end

        // Button held on nearly every tick without a clear, then a few ticks with clears
        // to bring the timer back down.
        apply_settings(16'd20, 16'd10, 10'd30);
        random_ticks(60, 35, 95, 0);
        random_ticks(60, 35, 50, 10);

        // Back to the reset periods for a last random stretch.
        apply_settings(BEEP_PERIOD_RST, BLINK_PERIOD_RST, BREATH_TOP_RST);
        random_ticks(60, 40, 50, 8);

        drain_results();
        repeat (4) @(posedge clk);

        $display("Run covered %0d ticks under %0d register settings; %0d results compared.",
                 ticks_sent, settings_applied + 1, results_checked);
        $display("It included a %0d-cycle output hold-off and a full breathing climb.",
                 LONG_HOLD_CYCLES);
        if (fail_count == 0 && results_due == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Generous ceiling: a correct run takes well under a tenth of this.
    initial begin : watchdog
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### led_beeper_tick_controller_core.f
src/lbt_pkg.sv
src/lbt_step.sv
src/led_beeper_tick_controller_core.sv
src/lbt_checker.sv
sim/lbt_tick_checker.sv
sim/tb_led_beeper_tick_controller_core.sv
